/* design/sbq_pkg.sv */
// shared types and constants for the screen box overlap query block
`default_nettype none
package sbq_pkg;
  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned CoordW = 20;
  localparam int unsigned TagW   = 16;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned VpW    = 13;
  localparam int unsigned QW     = 16;
  // one stored entry: tag, edges, key
  localparam int unsigned EntryW = TagW + 4 * CoordW + KeyW;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic {
    REG_VP_WIDTH  = 1'b0,
    REG_VP_HEIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [TagW-1:0]          tag;
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] bottom;
    logic [KeyW-1:0]          key;
  } entry_t;
endpackage
`default_nettype wire

/* design/sbq_ram.sv */
// generic ram with one write port and a registered read port
`default_nettype none
module sbq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* design/sbq_top_placeholder_unused.sv */
// selection scan unit: picks the next overlapping entry in key order
`default_nettype none
module sbq_scan (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic                           valid_i,
  input  wire sbq_pkg::entry_t                entry_i,
  input  wire logic [sbq_pkg::CoordW+1:0]     rx0_i,
  input  wire logic [sbq_pkg::CoordW+1:0]     rx1_i,
  input  wire logic [sbq_pkg::CoordW+1:0]     ry0_i,
  input  wire logic [sbq_pkg::CoordW+1:0]     ry1_i,
  input  wire logic [sbq_pkg::KeyW:0]         last_key_i,
  input  wire logic                           have_last_i,
  input  wire logic [15:0]                    idx_i,
  input  wire logic [15:0]                    last_idx_i,
  output logic                                found_o,
  output logic [sbq_pkg::TagW-1:0]            tag_o,
  output logic [sbq_pkg::KeyW-1:0]            key_o,
  output logic [15:0]                         idx_o
);
  import sbq_pkg::*;
  logic hit, after_last, better;
  logic signed [CoordW+1:0] l, t, r, b;

  // overlap and ordering test for the entry on the read port
  always_comb begin
    l = {{2{entry_i.left[CoordW-1]}}, entry_i.left};
    t = {{2{entry_i.top[CoordW-1]}}, entry_i.top};
    r = {{2{entry_i.right[CoordW-1]}}, entry_i.right};
    b = {{2{entry_i.bottom[CoordW-1]}}, entry_i.bottom};
    hit = !(r < $signed(rx0_i) || l > $signed(rx1_i) ||
            b < $signed(ry0_i) || t > $signed(ry1_i));
    after_last = !have_last_i ||
                 ({1'b0, entry_i.key} > last_key_i) ||
                 ({1'b0, entry_i.key} == last_key_i && idx_i > last_idx_i);
    better = !found_o || entry_i.key < key_o;
  end

  // running best candidate over one pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_o <= 1'b0;
    end else if (start_i) begin
      found_o <= 1'b0;
    end else if (valid_i && hit && after_last && better) begin
      found_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && hit && after_last && better) begin
      tag_o <= entry_i.tag;
      key_o <= entry_i.key;
      idx_o <= idx_i;
    end
  end
endmodule
`default_nettype wire

/* design/screen_box_overlap_query_top.sv */
// top level: command decode, entry memory and query sequencer
// query: a setup step, then (hits+1) scan passes over all stored entries
// each pass from the second on, or the only pass when nothing hits, gives one beat
// in the cycle after it; clear, insert and unused code leave busy low; no result stall
// config writes always ready; reset empties the table and sets viewport 1x1
// rate is set by the single scan unit comparing one memory entry per cycle
`default_nettype none
module screen_box_overlap_query_top #(
  parameter int unsigned MaxEntries = sbq_pkg::MaxEntriesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [sbq_pkg::TagW-1:0]      entry_tag_i,
  input  wire logic signed [sbq_pkg::CoordW-1:0] box_min_x_i,
  input  wire logic signed [sbq_pkg::CoordW-1:0] box_min_y_i,
  input  wire logic signed [sbq_pkg::CoordW-1:0] box_max_x_i,
  input  wire logic signed [sbq_pkg::CoordW-1:0] box_max_y_i,
  input  wire logic [sbq_pkg::KeyW-1:0]      distance_key_i,
  input  wire logic signed [sbq_pkg::QW-1:0] query_x_i,
  input  wire logic signed [sbq_pkg::QW-1:0] query_y_i,
  input  wire logic signed [sbq_pkg::QW-1:0] query_width_i,
  input  wire logic signed [sbq_pkg::QW-1:0] query_height_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [sbq_pkg::VpW-1:0]       cfg_data_i,
  output logic                               result_valid_o,
  output logic [sbq_pkg::TagW-1:0]           hit_tag_o,
  output logic                               no_hit_o,
  output logic                               last_hit_o
);
  import sbq_pkg::*;
  localparam int unsigned AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CW = $clog2(MaxEntries + 1);
  localparam logic signed [QW+1:0] SZero = '0;
  localparam logic signed [QW+1:0] SOne  = (QW+2)'(1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [VpW-1:0] vpw_q, vph_q;
  logic [CW-1:0]  count_q;
  logic [CW:0]    pos_q;
  logic           have_last_q;
  logic [KeyW:0]  last_key_q;
  logic [15:0]    last_idx_q;
  logic           any_q;
  logic signed [QW+1:0] qx_q, qy_q, qw_q, qh_q;
  logic signed [CoordW+1:0] rx0_q, rx1_q, ry0_q, ry1_q;
  entry_t wentry, rentry;
  logic   we, scan_start, rvalid_q, found;
  logic [TagW-1:0] ftag;
  logic [KeyW-1:0] fkey;
  logic [15:0]     fidx, ridx_q;
  logic [AW-1:0]   raddr;

  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != S_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpw_q <= VpW'(1);
      vph_q <= VpW'(1);
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_VP_WIDTH:  vpw_q <= cfg_data_i;
        REG_VP_HEIGHT: vph_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // entry memory
  assign wentry = '{tag: entry_tag_i, left: box_min_x_i, top: box_min_y_i,
                    right: box_max_x_i, bottom: box_max_y_i, key: distance_key_i};
  assign we = start && !busy && op_e'(operation_i) == OP_INSERT &&
              count_q < CW'(MaxEntries);
  assign raddr = pos_q[AW-1:0];

  sbq_ram #(.Width(EntryW), .Depth(MaxEntries)) u_ram (
    .clk_i, .we_i(we), .waddr_i(count_q[AW-1:0]), .wdata_i(wentry),
    .raddr_i(raddr), .rdata_o(rentry)
  );

  assign scan_start = (state_q == S_PREP) || (state_q == S_EMIT);

  sbq_scan u_scan (
    .clk_i, .rst_ni, .start_i(scan_start), .valid_i(rvalid_q), .entry_i(rentry),
    .rx0_i(rx0_q), .rx1_i(rx1_q), .ry0_i(ry0_q), .ry1_i(ry1_q),
    .last_key_i(last_key_q), .have_last_i(have_last_q), .idx_i(ridx_q),
    .last_idx_i(last_idx_q), .found_o(found), .tag_o(ftag), .key_o(fkey),
    .idx_o(fidx)
  );

  // clamp of the query rectangle, step by step
  logic signed [QW+1:0] w_ext, h_ext, xc, yc, wc, hc;
  always_comb begin
    w_ext = {5'b0, (vpw_q == '0) ? VpW'(1) : vpw_q};
    h_ext = {5'b0, (vph_q == '0) ? VpW'(1) : vph_q};
    xc = (qx_q < SZero) ? SZero : ((qx_q > w_ext - SOne) ? w_ext - SOne : qx_q);
    yc = (qy_q < SZero) ? SZero : ((qy_q > h_ext - SOne) ? h_ext - SOne : qy_q);
    wc = (qw_q < SOne) ? SOne : qw_q;
    hc = (qh_q < SOne) ? SOne : qh_q;
    if (wc > w_ext - xc) wc = w_ext - xc;
    if (hc > h_ext - yc) hc = h_ext - yc;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start && op_e'(operation_i) == OP_QUERY) state_d = S_PREP;
      S_PREP: state_d = S_SCAN;
      S_SCAN: if (pos_q >= (CW+1)'(count_q) && !rvalid_q) state_d = S_EMIT;
      S_EMIT: if (!found) state_d = S_IDLE;
              else state_d = S_SCAN;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pos_q <= '0;
      rvalid_q <= 1'b0;
      have_last_q <= 1'b0;
      any_q <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      rvalid_q <= (state_q == S_SCAN) && pos_q < (CW+1)'(count_q);
      if (state_q == S_IDLE && start) begin
        unique case (op_e'(operation_i))
          OP_CLEAR:  count_q <= '0;
          OP_INSERT: if (we) count_q <= count_q + CW'(1);
          OP_QUERY:  begin
            have_last_q <= 1'b0;
            any_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (scan_start) pos_q <= '0;
      else if (state_q == S_SCAN && pos_q < (CW+1)'(count_q)) pos_q <= pos_q + 1'b1;
      if (state_q == S_EMIT) begin
        if (found) begin
          have_last_q <= 1'b1;
          any_q <= 1'b1;
        end
      end
      // a beat is emitted one pass late so last_hit is known
      result_valid_o <= (state_q == S_EMIT) && (any_q || !found);
    end
  end

  // payload registers
  logic [TagW-1:0] pend_tag_q;
  always_ff @(posedge clk_i) begin
    ridx_q <= 16'(raddr);
    if (state_q == S_IDLE && start) begin
      qx_q <= {{2{query_x_i[QW-1]}}, query_x_i};
      qy_q <= {{2{query_y_i[QW-1]}}, query_y_i};
      qw_q <= {{2{query_width_i[QW-1]}}, query_width_i};
      qh_q <= {{2{query_height_i[QW-1]}}, query_height_i};
    end
    if (state_q == S_PREP) begin
      rx0_q <= (CoordW+2)'(xc <<< 4);
      ry0_q <= (CoordW+2)'(yc <<< 4);
      rx1_q <= (CoordW+2)'((xc + wc) <<< 4);
      ry1_q <= (CoordW+2)'((yc + hc) <<< 4);
    end
    if (state_q == S_EMIT) begin
      if (found) begin
        last_key_q <= {1'b0, fkey};
        last_idx_q <= fidx;
        pend_tag_q <= ftag;
      end
      hit_tag_o  <= any_q ? pend_tag_q : '0;
      no_hit_o   <= !any_q;
      last_hit_o <= !found;
    end
  end
endmodule
`default_nettype wire

/* tb/sbq_checker.sv */
// checker: watches the command, config and result channels, predicts and compares
module sbq_checker
  import sbq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               operation_i,
  input  logic [TagW-1:0]          entry_tag_i,
  input  logic signed [CoordW-1:0] box_min_x_i,
  input  logic signed [CoordW-1:0] box_min_y_i,
  input  logic signed [CoordW-1:0] box_max_x_i,
  input  logic signed [CoordW-1:0] box_max_y_i,
  input  logic [KeyW-1:0]          distance_key_i,
  input  logic signed [QW-1:0]     query_x_i,
  input  logic signed [QW-1:0]     query_y_i,
  input  logic signed [QW-1:0]     query_width_i,
  input  logic signed [QW-1:0]     query_height_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [VpW-1:0]           cfg_data_i,
  input  logic                     result_valid_o,
  input  logic [TagW-1:0]          hit_tag_o,
  input  logic                     no_hit_o,
  input  logic                     last_hit_o,
  output int unsigned              err_count,
  output int unsigned              pending
);

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic            no_hit;
    logic            last;
  } hit_beat_t;

  hit_beat_t   hits_due_q[$];
  entry_t      box_table[MaxEntriesDef];
  int unsigned box_count;
  logic [VpW-1:0] vp_width;
  logic [VpW-1:0] vp_height;

  task automatic report(input string msg);
    $display("sbq mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // clamp the rectangle, collect overlaps and order them by key, ties by slot
  task automatic predict_query();
    longint    vw, vh, qx, qy, qw, qh, rx0, ry0, rx1, ry1;
    int        order_q[$];
    int        m;
    hit_beat_t beat;
    vw = (vp_width == 0) ? 1 : longint'(vp_width);
    vh = (vp_height == 0) ? 1 : longint'(vp_height);
    qx = longint'(query_x_i);
    qy = longint'(query_y_i);
    qw = longint'(query_width_i);
    qh = longint'(query_height_i);
    if (qx < 0) qx = 0;
    if (qx > vw - 1) qx = vw - 1;
    if (qy < 0) qy = 0;
    if (qy > vh - 1) qy = vh - 1;
    if (qw < 1) qw = 1;
    if (qh < 1) qh = 1;
    if (qw > vw - qx) qw = vw - qx;
    if (qh > vh - qy) qh = vh - qy;
    rx0 = qx * 16;
    ry0 = qy * 16;
    rx1 = (qx + qw) * 16;
    ry1 = (qy + qh) * 16;
    for (int i = 0; i < box_count; i++) begin
      if (longint'($signed(box_table[i].right)) < rx0 ||
          longint'($signed(box_table[i].left)) > rx1 ||
          longint'($signed(box_table[i].bottom)) < ry0 ||
          longint'($signed(box_table[i].top)) > ry1) continue;
      m = order_q.size();
      while (m > 0 && box_table[order_q[m-1]].key > box_table[i].key) m--;
      order_q.insert(m, i);
    end
    if (order_q.size() == 0) begin
      beat = '{tag: '0, no_hit: 1'b1, last: 1'b1};
      hits_due_q.insert(hits_due_q.size(), beat);
    end else begin
      foreach (order_q[k]) begin
        beat = '{tag: box_table[order_q[k]].tag, no_hit: 1'b0,
                 last: (k == order_q.size() - 1)};
        hits_due_q.insert(hits_due_q.size(), beat);
      end
    end
  endtask

  // result beats are checked before the command of the same edge is applied
  always @(posedge clk_i or negedge rst_ni) begin
    hit_beat_t want;
    if (!rst_ni) begin
      hits_due_q.delete();
      box_count = 0;
      vp_width  = 1;
      vp_height = 1;
      err_count = 0;
      pending  <= 0;
    end else begin
      if (result_valid_o) begin
        if (hits_due_q.size() == 0) begin
          report($sformatf("unexpected beat tag %h no_hit %b last %b",
                           hit_tag_o, no_hit_o, last_hit_o));
        end else begin
          want = hits_due_q.pop_front();
          if (hit_tag_o !== want.tag)
            report($sformatf("hit_tag %h, want %h", hit_tag_o, want.tag));
          if (no_hit_o !== want.no_hit)
            report($sformatf("no_hit %b, want %b", no_hit_o, want.no_hit));
          if (last_hit_o !== want.last)
            report($sformatf("last_hit %b, want %b", last_hit_o, want.last));
        end
      end
      // config beats
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_VP_WIDTH) vp_width = cfg_data_i;
        else vp_height = cfg_data_i;
      end
      // command beats
      if (start && !busy) begin
        case (op_e'(operation_i))
          OP_CLEAR: box_count = 0;
          OP_INSERT: begin
            if (box_count < MaxEntriesDef) begin
              box_table[box_count] = '{tag: entry_tag_i, left: box_min_x_i,
                                       top: box_min_y_i, right: box_max_x_i,
                                       bottom: box_max_y_i, key: distance_key_i};
              box_count++;
            end
          end
          OP_QUERY: predict_query();
          default: ;
        endcase
      end
      pending <= hits_due_q.size();
    end
  end

endmodule

/* tb/screen_box_overlap_query_top_tb.sv */
// testbench top: stimulus for the screen box overlap query block and the verdict
module screen_box_overlap_query_top_tb;
  import sbq_pkg::*;

  localparam int unsigned ItemTarget = 140;
  localparam longint      CycleLimit = 3000000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [1:0]               operation_i;
  logic [TagW-1:0]          entry_tag_i;
  logic signed [CoordW-1:0] box_min_x_i;
  logic signed [CoordW-1:0] box_min_y_i;
  logic signed [CoordW-1:0] box_max_x_i;
  logic signed [CoordW-1:0] box_max_y_i;
  logic [KeyW-1:0]          distance_key_i;
  logic signed [QW-1:0]     query_x_i;
  logic signed [QW-1:0]     query_y_i;
  logic signed [QW-1:0]     query_width_i;
  logic signed [QW-1:0]     query_height_i;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic                     cfg_index_i;
  logic [VpW-1:0]           cfg_data_i;
  logic                     result_valid_o;
  logic [TagW-1:0]          hit_tag_o;
  logic                     no_hit_o;
  logic                     last_hit_o;
  int unsigned              err_count;
  int unsigned              pending;

  longint      cycle_cnt;
  int unsigned items_sent;
  int unsigned burst_left;
  int          cur_w;
  int          cur_h;

  screen_box_overlap_query_top u_dut (.*);
  sbq_checker u_checker (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("screen_box_overlap_query_top_tb: done, errors");
      $finish;
    end
  end

  // one command beat, after a random gap unless in a burst
  task automatic send_cmd(input op_e op, input logic [15:0] tag,
                          input logic [19:0] l, t, r, b, input logic [31:0] key,
                          input logic [15:0] qx, qy, qw, qh);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 9) == 0) burst_left = 12;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    operation_i    <= op;
    entry_tag_i    <= tag;
    box_min_x_i    <= l;
    box_min_y_i    <= t;
    box_max_x_i    <= r;
    box_max_y_i    <= b;
    distance_key_i <= key;
    query_x_i      <= qx;
    query_y_i      <= qy;
    query_width_i  <= qw;
    query_height_i <= qh;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  task automatic insert_box(input logic [15:0] tag, input logic [19:0] l, t, r, b,
                            input logic [31:0] key);
    send_cmd(OP_INSERT, tag, l, t, r, b, key, 16'($urandom), 16'($urandom),
             16'($urandom), 16'($urandom));
  endtask

  task automatic query_rect(input logic [15:0] qx, qy, qw, qh);
    send_cmd(OP_QUERY, 16'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
             20'($urandom), $urandom, qx, qy, qw, qh);
  endtask

  task automatic other_op(input op_e op);
    send_cmd(op, 16'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
             20'($urandom), $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom));
  endtask

  // box mostly inside the viewport area, sometimes inverted, keys often tied
  task automatic random_insert();
    int l, t, r, b;
    logic [31:0] key;
    l = $urandom_range(0, cur_w * 16 + 48) - 32;
    t = $urandom_range(0, cur_h * 16 + 48) - 32;
    r = l + $urandom_range(0, 300);
    b = t + $urandom_range(0, 300);
    if ($urandom_range(0, 9) == 0) begin
      r = l - $urandom_range(1, 40);
    end
    key = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
    insert_box(16'($urandom), 20'(l), 20'(t), 20'(r), 20'(b), key);
  endtask

  task automatic random_query();
    int qx, qy, qw, qh;
    qx = $urandom_range(0, cur_w + 4) - 2;
    qy = $urandom_range(0, cur_h + 4) - 2;
    qw = $urandom_range(0, 24) - 2;
    qh = $urandom_range(0, 24) - 2;
    if ($urandom_range(0, 5) == 0) begin
      qw = $urandom_range(0, cur_w + 8);
      qh = $urandom_range(0, cur_h + 8);
    end
    query_rect(16'(qx), 16'(qy), 16'(qw), 16'(qh));
  endtask

  // wait for the block to drain, with start low
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [VpW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_viewport(input int w, input int h);
    write_reg(REG_VP_WIDTH, VpW'(w));
    write_reg(REG_VP_HEIGHT, VpW'(h));
    cur_w = (w == 0) ? 1 : w;
    cur_h = (h == 0) ? 1 : h;
  endtask

  int vp_w_list[7] = '{0, 64, 4096, 8191, 1, 200, 8191};
  int vp_h_list[7] = '{0, 48, 4096, 8191, 4096, 120, 1};

  initial begin
    int sel, n, phase_end;
    cycle_cnt      = 0;
    items_sent     = 0;
    burst_left     = 0;
    cur_w          = 1;
    cur_h          = 1;
    rst_ni         = 1'b0;
    start          = 1'b0;
    operation_i    = OP_NONE;
    entry_tag_i    = '0;
    box_min_x_i    = '0;
    box_min_y_i    = '0;
    box_max_x_i    = '0;
    box_max_y_i    = '0;
    distance_key_i = '0;
    query_x_i      = '0;
    query_y_i      = '0;
    query_width_i  = '0;
    query_height_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_VP_WIDTH;
    cfg_data_i     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset viewport of one pixel, query spans 0..16 on both axes
    query_rect(0, 0, 1, 1);
    insert_box(16'h0000, -20'sd524288, -20'sd524288, 20'sd524287, 20'sd524287,
               32'hffff_ffff);
    insert_box(16'hffff, 0, 0, 0, 0, 32'h0);
    insert_box(16'h1234, 100, 100, -100, -100, 32'd5);
    insert_box(16'h5555, 16, 16, 40, 40, 32'd5);
    insert_box(16'haaaa, 17, 0, 30, 30, 32'd5);
    insert_box(16'h0007, -20, -20, -1, 5, 32'd5);
    insert_box(16'h0008, 0, 0, 16, 16, 32'd5);
    query_rect(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    query_rect(0, 0, 1, 1);
    other_op(OP_NONE);
    query_rect(0, 0, 0, 0);
    query_rect(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    other_op(OP_CLEAR);
    query_rect(0, 0, 1, 1);
    insert_box(16'h0009, 0, 0, 16, 16, 32'h0);
    other_op(OP_NONE);
    query_rect(0, 0, 1, 1);

    // hold off until the block has emptied once mid-stream
    settle();
    query_rect(3, 3, 3, 3);

    for (int p = 0; p < 7; p++) begin
      settle();
      set_viewport(vp_w_list[p], vp_h_list[p]);
      // fill past capacity once so the overflow drop is exercised
      if (p == 1) begin
        other_op(OP_CLEAR);
        for (int i = 0; i < 66; i++) random_insert();
        query_rect(0, 0, 64, 48);
        random_query();
      end
      // every viewport gets at least one group of traffic
      phase_end = (p + 1) * ItemTarget / 7;
      if (phase_end <= items_sent) phase_end = items_sent + 1;
      while (items_sent < phase_end) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          // well-formed: a clear most times, a handful of boxes, a few queries
          if ($urandom_range(0, 2) != 0) other_op(OP_CLEAR);
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) random_insert();
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) random_query();
        end else if (sel == 7) begin
          other_op(OP_NONE);
        end else if (sel == 8) begin
          insert_box(16'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                     20'($urandom), $urandom);
        end else begin
          query_rect(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
      end
    end

    settle();
    if (err_count == 0) begin
      $display("screen_box_overlap_query_top_tb: done, clean");
    end else begin
      $display("screen_box_overlap_query_top_tb: done, errors");
    end
    $finish;
  end

endmodule
